/* hw/rtl/ucc_pkg.sv */
// Shared types, status codes and a helper function for the UDP checksum block.
package ucc_pkg;

   // Byte counter saturates here.
   localparam logic [16:0] BYTE_LIMIT     = 17'h1FFFF;
   // Longest header length accepted in generate mode.
   localparam logic [15:0] GEN_MAX_LENGTH = 16'd65515;
   // Shortest legal UDP length (the header itself).
   localparam logic [15:0] MIN_LENGTH     = 16'd8;
   localparam logic [7:0]  PROTOCOL_RESET = 8'd17;
   localparam logic [15:0] ALL_ONES       = 16'hFFFF;

   // Command and byte-count codes of the request.
   localparam logic       CMD_VERIFY = 1'b1;
   localparam logic [1:0] BYTES_ONE  = 2'd1;

   // Register index of the protocol number.
   localparam logic CSR_PROTOCOL_INDEX = 1'b0;

   // Result status codes.
   localparam logic [2:0] STATUS_OK       = 3'd0;
   localparam logic [2:0] STATUS_RUNT     = 3'd1;
   localparam logic [2:0] STATUS_BAD_LEN  = 3'd2;
   localparam logic [2:0] STATUS_MISMATCH = 3'd3;
   localparam logic [2:0] STATUS_DISABLED = 3'd4;
   localparam logic [2:0] STATUS_TOO_LONG = 3'd5;

   // Datagram summary handed to the finishing stage on the last word.
   typedef struct packed {
      logic [15:0] sum;
      logic [15:0] addr_sum;
      logic [16:0] total;
      logic [15:0] hdr_len;
      logic [15:0] stored;
      logic [15:0] source_port;
      logic [15:0] dest_port;
      logic        verify;
   } frame_type;

   // One result item.
   typedef struct packed {
      logic [15:0] checksum;
      logic [2:0]  status;
      logic [15:0] source_port;
      logic [15:0] dest_port;
      logic [15:0] payload_bytes;
   } result_type;

   // End-around carry fold of a sum of up to eight 16-bit terms. The result is
   // zero only when every term was zero, as with repeated one's-complement adds.
   function automatic logic [15:0] fold19(input logic [18:0] s);
      logic [16:0] t;
      logic [15:0] r;
      t = {1'b0, s[15:0]} + {14'd0, s[18:16]};
      r = t[15:0] + {15'd0, t[16]};
      return r;
   endfunction

endpackage

/* hw/rtl/ucc_finish.sv */
// Finishing logic: pseudo-header sum, wire checksum and status of a datagram.
module ucc_finish (
   input  ucc_pkg::frame_type  frame,
   input  logic [7:0]          protocol,
   output ucc_pkg::result_type result
);
   import ucc_pkg::*;

   logic [18:0] total_sum;
   logic [15:0] folded;
   logic [15:0] cs;
   logic [2:0]  status;

   // Add the pseudo-header words to the datagram sum and invert; a zero result is sent as all ones.
   always_comb begin
      total_sum = {3'd0, frame.sum} + {3'd0, frame.addr_sum}
                + {11'd0, protocol} + {3'd0, frame.hdr_len};
      folded    = fold19(total_sum);
      cs        = ~folded;
      if (cs == 16'd0) begin
         cs = ALL_ONES;
      end
   end

   // Status in order of priority.
   always_comb begin
      if (frame.total < {1'b0, MIN_LENGTH}) begin
         status = STATUS_RUNT;
      end else if (frame.hdr_len < MIN_LENGTH || {1'b0, frame.hdr_len} > frame.total) begin
         status = STATUS_BAD_LEN;
      end else if (frame.verify != CMD_VERIFY) begin
         status = (frame.hdr_len > GEN_MAX_LENGTH) ? STATUS_TOO_LONG : STATUS_OK;
      end else if (frame.stored == 16'd0) begin
         status = STATUS_DISABLED;
      end else begin
         status = (cs != frame.stored) ? STATUS_MISMATCH : STATUS_OK;
      end
   end

   // Assemble the result; error cases clear the checksum or the length.
   always_comb begin
      result.status      = status;
      result.source_port = frame.source_port;
      result.dest_port   = frame.dest_port;
      case (status)
         STATUS_RUNT, STATUS_BAD_LEN, STATUS_TOO_LONG: result.checksum = 16'd0;
         default:                                      result.checksum = cs;
      endcase
      case (status)
         STATUS_OK, STATUS_DISABLED: result.payload_bytes = frame.hdr_len - MIN_LENGTH;
         default:                    result.payload_bytes = 16'd0;
      endcase
   end

endmodule

/* hw/rtl/udp_checksum_check_generate.sv */
// Top level of the UDP checksum generator and checker with its register port.
// Throughput: one request word per cycle while the result side keeps taking results, with no gaps between datagrams.
// The summary of a datagram is registered when its last word is accepted, and its result
// is then registered from the finishing stage into the result register.
// Reset (synchronous, active high) clears the running sum, byte count, header bytes, mode,
// address sum and the valid bits of both pipeline stages, and sets the protocol number to 17.
module udp_checksum_check_generate (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata from bit 0: data_word[15:0], bytes_valid[17:16], source_address[49:18],
   // destination_address[81:50], zero fill.
   input  logic [87:0] req_tdata,
   // tuser from bit 0: command[0], first_word[1].
   input  logic [1:0]  req_tuser,
   input  logic        req_tlast,
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata from bit 0: checksum_value[15:0], status[18:16], source_port[34:19],
   // destination_port[50:35], payload_length[66:51], zero fill.
   output logic [71:0] rsp_tdata,
   // Configuration port.
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import ucc_pkg::*;

   // Request fields.
   logic [15:0] data_word;
   logic [1:0]  bytes_valid;
   logic [31:0] source_ip;
   logic [31:0] dest_ip;
   logic        command;
   logic        first_word;
   logic        req_accept;

   // Datagram state.
   logic [7:0]       protocol_ff, protocol_in;
   logic [15:0]      sum_ff, sum_in;
   logic [16:0]      bytes_ff, bytes_in;
   logic [7:0][7:0]  hdr_ff, hdr_in;
   logic             mode_ff, mode_in;
   logic [15:0]      addr_sum_ff, addr_sum_in;

   // Pipeline stages.
   logic       fin_valid_ff, fin_valid_in;
   frame_type  fin_ff, fin_in;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff, rsp_in;
   result_type fin_result;
   logic       advance;

   // Word accumulator intermediates.
   logic [16:0]     p0, p1;
   logic            take1;
   logic [7:0][7:0] hdr_eff, hdr_new;
   logic [15:0]     sum_eff;
   logic [15:0]     hl_eff;
   logic [15:0]     term0, term1;
   logic [15:0]     sum_new;
   logic [15:0]     addr_sum_new;
   logic            mode_new;
   logic [17:0]     addr_total;
   logic            csr_write;

   // Contribution of one byte to the sum: header bytes below six and payload
   // bytes below the header length count; the checksum bytes count as zero.
   function automatic logic [15:0] byte_term(input logic [16:0] pos, input logic [7:0] b,
                                             input logic [15:0] hl);
      logic counted;
      counted = (pos < 17'd6) || (pos >= 17'd8 && pos < {1'b0, hl});
      if (!counted) begin
         return 16'd0;
      end
      return pos[0] ? {8'h00, b} : {b, 8'h00};
   endfunction

   assign data_word   = req_tdata[15:0];
   assign bytes_valid = req_tdata[17:16];
   assign source_ip   = req_tdata[49:18];
   assign dest_ip     = req_tdata[81:50];
   assign command     = req_tuser[0];
   assign first_word  = req_tuser[1];

   // Flow control: the finishing stage moves on whenever the result register is empty or its result is taken.
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !fin_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;

   // Apply the first-word clear, place the bytes of this word and add them.
   always_comb begin
      hdr_eff = first_word ? '0 : hdr_ff;
      sum_eff = first_word ? 16'd0 : sum_ff;
      p0      = first_word ? 17'd0 : bytes_ff;
      hl_eff  = {hdr_eff[4], hdr_eff[5]};
      take1   = (bytes_valid != BYTES_ONE);
      p1      = (p0 < BYTE_LIMIT) ? p0 + 17'd1 : p0;

      hdr_new = hdr_eff;
      if (p0 < 17'd8) begin
         hdr_new[p0[2:0]] = data_word[15:8];
      end
      if (take1 && p1 < 17'd8) begin
         hdr_new[p1[2:0]] = data_word[7:0];
      end

      term0 = byte_term(p0, data_word[15:8], hl_eff);
      term1 = take1 ? byte_term(p1, data_word[7:0], hl_eff) : 16'd0;
      sum_new = fold19({3'd0, sum_eff} + {3'd0, term0} + {3'd0, term1});

      if (take1 && p1 < BYTE_LIMIT) begin
         bytes_in = p1 + 17'd1;
      end else begin
         bytes_in = p1;
      end

      // Addresses and mode are latched on a first word and kept across datagrams.
      addr_total   = {2'd0, source_ip[31:16]} + {2'd0, source_ip[15:0]}
                   + {2'd0, dest_ip[31:16]} + {2'd0, dest_ip[15:0]};
      addr_sum_new = first_word ? fold19({1'b0, addr_total}) : addr_sum_ff;
      mode_new     = first_word ? command : mode_ff;
   end

   // Snapshot of the finished datagram.
   always_comb begin
      fin_in.sum         = sum_new;
      fin_in.addr_sum    = addr_sum_new;
      fin_in.total       = bytes_in;
      fin_in.hdr_len     = {hdr_new[4], hdr_new[5]};
      fin_in.stored      = {hdr_new[6], hdr_new[7]};
      fin_in.source_port = {hdr_new[0], hdr_new[1]};
      fin_in.dest_port   = {hdr_new[2], hdr_new[3]};
      fin_in.verify      = mode_new;
   end

   // Next datagram state; a last word clears the frame fields.
   always_comb begin
      sum_in      = sum_ff;
      hdr_in      = hdr_ff;
      mode_in     = mode_ff;
      addr_sum_in = addr_sum_ff;
      if (req_accept) begin
         mode_in     = mode_new;
         addr_sum_in = addr_sum_new;
         if (req_tlast) begin
            sum_in = 16'd0;
            hdr_in = '0;
         end else begin
            sum_in = sum_new;
            hdr_in = hdr_new;
         end
      end
   end

   ucc_finish u_finish (
      .frame    (fin_ff),
      .protocol (protocol_ff),
      .result   (fin_result)
   );

   // Pipeline valid bits and result register load.
   always_comb begin
      fin_valid_in = (fin_valid_ff && !advance) || (req_accept && req_tlast);
      rsp_valid_in = advance ? fin_valid_ff : rsp_valid_ff;
      rsp_in       = advance ? fin_result : rsp_ff;
   end

   // Protocol number register.
   assign csr_write   = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign protocol_in = (csr_write && csr_paddr[2] == CSR_PROTOCOL_INDEX) ?
                        csr_pwdata[7:0] : protocol_ff;
   assign csr_pready  = 1'b1;
   assign csr_prdata  = (csr_paddr[2] == CSR_PROTOCOL_INDEX) ? {24'd0, protocol_ff} : 32'd0;

   // State and control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         protocol_ff  <= PROTOCOL_RESET;
         sum_ff       <= 16'd0;
         bytes_ff     <= 17'd0;
         hdr_ff       <= '0;
         mode_ff      <= 1'b0;
         addr_sum_ff  <= 16'd0;
         fin_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         protocol_ff  <= protocol_in;
         sum_ff       <= sum_in;
         if (req_accept) begin
            bytes_ff <= req_tlast ? 17'd0 : bytes_in;
         end
         hdr_ff       <= hdr_in;
         mode_ff      <= mode_in;
         addr_sum_ff  <= addr_sum_in;
         fin_valid_ff <= fin_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers of the two stages.
   always_ff @(posedge clock) begin
      if (req_accept && req_tlast) begin
         fin_ff <= fin_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_ff.payload_bytes, rsp_ff.dest_port, rsp_ff.source_port,
                        rsp_ff.status, rsp_ff.checksum};

`ifndef ASSERT_OFF
   // A held datagram summary must block a new request while the result waits.
   a_fin_block: assert property (@(posedge clock) disable iff (reset)
      (fin_valid_ff && !advance) |-> !req_tready)
      else $error("request accepted while the finishing stage was stalled");

   // Error results carry no checksum.
   a_err_checksum: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.status == STATUS_RUNT || rsp_ff.status == STATUS_BAD_LEN ||
       rsp_ff.status == STATUS_TOO_LONG)) |-> (rsp_ff.checksum == 16'd0))
      else $error("checksum present on an error result");

   // A good or unchecked result always has a nonzero wire checksum.
   a_ok_checksum: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.status == STATUS_OK || rsp_ff.status == STATUS_DISABLED))
      |-> (rsp_ff.checksum != 16'd0))
      else $error("zero wire checksum on a good result");

   // A last word always clears the byte count for the next datagram.
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_tlast) |=> (bytes_ff == 17'd0 && fin_valid_ff))
      else $error("frame state not cleared after the last word");
`endif

endmodule

/* bench/tb_udp_checksum_check_generate.sv */
// Self-checking testbench for the UDP checksum generator and checker.

// One request word as the bench sees it, before packing onto the bus.
typedef struct packed {
   logic        command;
   logic        first;
   logic        last;
   logic [15:0] data;
   logic [1:0]  bytes_valid;
   logic [31:0] source_ip;
   logic [31:0] dest_ip;
} udp_word_type;

// Predicts the checksum results and checks them against what the block returns.
class checksum_scoreboard;
   logic [7:0]  protocol;
   logic [15:0] running_sum;
   logic [16:0] bytes_seen;
   logic [15:0] header_length;
   logic [15:0] stored_checksum;
   logic [31:0] port_pair;
   logic        mode_flag;
   logic [63:0] address_pair;
   ucc_pkg::result_type expected_results[$];
   int unsigned mismatches;

   function new();
      protocol     = ucc_pkg::PROTOCOL_RESET;
      mode_flag    = 1'b0;
      address_pair = '0;
      mismatches   = 0;
      clear_frame();
   endfunction

   function void clear_frame();
      running_sum     = '0;
      bytes_seen      = '0;
      header_length   = '0;
      stored_checksum = '0;
      port_pair       = '0;
   endfunction

   // One's-complement add with end-around carry.
   function void add_ones(input logic [15:0] v);
      logic [16:0] s;
      s = {1'b0, running_sum} + {1'b0, v};
      running_sum = s[15:0] + {15'd0, s[16]};
   endfunction

   function logic [15:0] put_half(input logic [15:0] f, input logic [7:0] b, input logic even);
      return even ? {b, f[7:0]} : {f[15:8], b};
   endfunction

   // Header bytes land in their fields; the checksum bytes are summed as zero,
   // and bytes past the header length are not summed at all.
   function void take_byte(input logic [7:0] b);
      logic        even;
      logic [15:0] part;
      even = ~bytes_seen[0];
      part = even ? {b, 8'h00} : {8'h00, b};
      if (bytes_seen < 17'd8) begin
         case (bytes_seen[2:1])
            2'd0: port_pair[31:16] = put_half(port_pair[31:16], b, even);
            2'd1: port_pair[15:0]  = put_half(port_pair[15:0], b, even);
            2'd2: header_length    = put_half(header_length, b, even);
            default: stored_checksum = put_half(stored_checksum, b, even);
         endcase
         if (bytes_seen < 17'd6) add_ones(part);
      end else if (bytes_seen < {1'b0, header_length}) begin
         add_ones(part);
      end
      if (bytes_seen != ucc_pkg::BYTE_LIMIT) bytes_seen++;
   endfunction

   // Advances the datagram state by one request word; returns 1 with a result
   // when the word closes the datagram.
   function bit step(input udp_word_type w, output ucc_pkg::result_type res);
      logic [15:0] cs;
      logic [2:0]  st;
      res = '0;
      if (w.first) begin
         clear_frame();
         mode_flag    = w.command;
         address_pair = {w.source_ip, w.dest_ip};
      end
      take_byte(w.data[15:8]);
      if (w.bytes_valid != ucc_pkg::BYTES_ONE) take_byte(w.data[7:0]);
      if (!w.last) return 1'b0;

      // Pseudo-header: both addresses, the protocol and the length field.
      add_ones(address_pair[63:48]);
      add_ones(address_pair[47:32]);
      add_ones(address_pair[31:16]);
      add_ones(address_pair[15:0]);
      add_ones({8'h00, protocol});
      add_ones(header_length);
      cs = ~running_sum;
      if (cs == 16'h0000) cs = ucc_pkg::ALL_ONES;

      if (bytes_seen < 17'd8)
         st = ucc_pkg::STATUS_RUNT;
      else if (header_length < ucc_pkg::MIN_LENGTH || {1'b0, header_length} > bytes_seen)
         st = ucc_pkg::STATUS_BAD_LEN;
      else if (mode_flag != ucc_pkg::CMD_VERIFY)
         st = (header_length > ucc_pkg::GEN_MAX_LENGTH) ? ucc_pkg::STATUS_TOO_LONG
                                                         : ucc_pkg::STATUS_OK;
      else if (stored_checksum == 16'h0000)
         st = ucc_pkg::STATUS_DISABLED;
      else
         st = (cs != stored_checksum) ? ucc_pkg::STATUS_MISMATCH : ucc_pkg::STATUS_OK;

      res.status   = st;
      res.checksum = (st == ucc_pkg::STATUS_RUNT || st == ucc_pkg::STATUS_BAD_LEN ||
                      st == ucc_pkg::STATUS_TOO_LONG) ? 16'h0000 : cs;
      res.source_port = port_pair[31:16];
      res.dest_port   = port_pair[15:0];
      res.payload_bytes = (st == ucc_pkg::STATUS_OK || st == ucc_pkg::STATUS_DISABLED) ?
                          header_length - ucc_pkg::MIN_LENGTH : 16'h0000;
      clear_frame();
      return 1'b1;
   endfunction

   function void note_request(input udp_word_type w);
      ucc_pkg::result_type res;
      if (step(w, res)) expected_results.push_back(res);
   endfunction

   function void compare(input string name, input logic [15:0] e, input logic [15:0] a);
      if (e !== a) begin
         $error("%s: expected %h, actual %h", name, e, a);
         mismatches++;
      end
   endfunction

   function void check_result(input logic [71:0] d);
      ucc_pkg::result_type e;
      if (expected_results.size() == 0) begin
         $error("Result %h arrived with no expected result waiting", d);
         mismatches++;
         return;
      end
      e = expected_results.pop_front();
      compare("checksum_value", e.checksum, d[15:0]);
      compare("status", {13'd0, e.status}, {13'd0, d[18:16]});
      compare("source_port", e.source_port, d[34:19]);
      compare("destination_port", e.dest_port, d[50:35]);
      compare("payload_length", e.payload_bytes, d[66:51]);
   endfunction

   function int pending();
      return expected_results.size();
   endfunction
endclass

module tb_udp_checksum_check_generate;

   localparam logic       CMD_GENERATE = ~ucc_pkg::CMD_VERIFY;
   localparam logic [1:0] BYTES_TWO    = 2'd2;

   typedef enum logic [1:0] {STORE_CORRECT, STORE_ZERO, STORE_RANDOM} stored_kind_type;
   typedef enum logic [1:0] {FILL_RANDOM, FILL_ZEROS, FILL_ONES} fill_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [87:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [71:0] rsp_tdata;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   checksum_scoreboard book;
   udp_word_type datagram_words[$];
   int unsigned  words_sent;
   bit           req_gaps_on;
   bit           rsp_gaps_on;

   udp_checksum_check_generate DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The result side stalls at random while gaps are enabled.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_tready = rsp_gaps_on ? ($urandom_range(0, 99) >= 36) : 1'b1;
      end
   end

   // Every result accepted by the bench is checked against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) book.check_result(rsp_tdata);
   end

   initial begin
      #50_000_000;
      $display("Mismatches found");
      $finish;
   end

   function automatic logic [15:0] pick16(input fill_type fill);
      case (fill)
         FILL_ZEROS: return 16'h0000;
         FILL_ONES:  return 16'hFFFF;
         default:    return 16'($urandom);
      endcase
   endfunction

   // Drives one request and waits until the block takes it.
   task automatic send_request(input udp_word_type w);
      @(negedge clock);
      while (req_gaps_on && $urandom_range(0, 99) < 36) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {6'd0, w.dest_ip, w.source_ip, w.bytes_valid, w.data};
      req_tuser  = {w.first, w.command};
      req_tlast  = w.last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      book.note_request(w);
      words_sent++;
   endtask

   // Holds off the sender until every predicted result has been returned.
   task automatic wait_for_results();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (book.pending() != 0) @(posedge clock);
   endtask

   // Writes the protocol number and reads it back once the write has landed.
   task automatic write_protocol(input logic [7:0] value);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = {ucc_pkg::CSR_PROTOCOL_INDEX, 2'b00};
      csr_pwdata  = $urandom;
      csr_pwdata[7:0] = value;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      book.protocol = value;
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      if (csr_prdata !== {24'd0, value}) begin
         $error("protocol_number: expected %h, actual %h", {24'd0, value}, csr_prdata);
         book.mismatches++;
      end
   endtask

   // Builds a datagram into datagram_words. The stored checksum is either zero,
   // random, or the correct one worked out by a scratch predictor.
   task automatic build_datagram(input logic cmd, input int nbytes, input logic [15:0] hl,
                                 input stored_kind_type kind, input fill_type fill);
      logic [63:0]  hdr;
      logic [31:0]  src, dst;
      logic [15:0]  stored;
      udp_word_type w;
      int           nw;
      ucc_pkg::result_type res;
      checksum_scoreboard  scratch;
      hdr = {pick16(fill), pick16(fill), hl, 16'h0000};
      src = {pick16(fill), pick16(fill)};
      dst = {pick16(fill), pick16(fill)};
      nw  = (nbytes + 1) / 2;
      datagram_words.delete();
      for (int i = 0; i < nw; i++) begin
         w.command   = (i == 0) ? cmd : 1'($urandom);
         w.first     = (i == 0);
         w.last      = (i == nw - 1);
         w.source_ip = (i == 0) ? src : $urandom;
         w.dest_ip   = (i == 0) ? dst : $urandom;
         w.data      = (i < 4) ? hdr[63 - 16 * i -: 16] : pick16(fill);
         if (2 * i + 1 == nbytes) begin
            w.bytes_valid = ucc_pkg::BYTES_ONE;
         end else begin
            w.bytes_valid = 2'($urandom_range(0, 3));
            if (w.bytes_valid == ucc_pkg::BYTES_ONE) w.bytes_valid = BYTES_TWO;
         end
         datagram_words.push_back(w);
      end
      stored = 16'h0000;
      case (kind)
         STORE_RANDOM: stored = 16'($urandom_range(1, 65535));
         STORE_CORRECT: begin
            scratch = new();
            scratch.protocol = book.protocol;
            foreach (datagram_words[i])
               if (scratch.step(datagram_words[i], res)) stored = res.checksum;
         end
         default: stored = 16'h0000;
      endcase
      if (nw > 3) datagram_words[3].data = stored;
   endtask

   task automatic send_datagram();
      foreach (datagram_words[i]) send_request(datagram_words[i]);
   endtask

   // Mostly well-formed datagrams, with some runts and length faults.
   task automatic random_datagram();
      int              nbytes, r;
      logic [15:0]     hl;
      logic            cmd;
      stored_kind_type kind;
      fill_type        fill;
      cmd = 1'($urandom_range(0, 1));
      r = $urandom_range(0, 99);
      nbytes = (r < 8) ? $urandom_range(1, 7) :
               (r < 97) ? $urandom_range(8, 48) : $urandom_range(49, 300);
      r = $urandom_range(0, 99);
      if (r < 65)      hl = 16'(nbytes);
      else if (r < 75) hl = 16'($urandom_range(0, 7));
      else if (r < 85) hl = 16'(nbytes + $urandom_range(1, 20));
      else if (r < 93) hl = 16'($urandom_range(8, nbytes));
      else             hl = 16'($urandom_range(0, 65535));
      r = $urandom_range(0, 99);
      if (cmd != ucc_pkg::CMD_VERIFY) kind = STORE_RANDOM;
      else if (r < 60)                kind = STORE_CORRECT;
      else if (r < 75)                kind = STORE_ZERO;
      else                            kind = STORE_RANDOM;
      r = $urandom_range(0, 99);
      fill = (r < 3) ? FILL_ZEROS : (r < 6) ? FILL_ONES : FILL_RANDOM;
      build_datagram(cmd, nbytes, hl, kind, fill);
      send_datagram();
   endtask

   // Loose words with arbitrary flags: continuations, one-word datagrams and
   // short words in the middle of a datagram.
   task automatic send_noise();
      udp_word_type w;
      repeat ($urandom_range(1, 4)) begin
         w.command     = 1'($urandom_range(0, 1));
         w.first       = ($urandom_range(0, 99) < 30);
         w.last        = ($urandom_range(0, 99) < 30);
         w.data        = 16'($urandom);
         w.bytes_valid = 2'($urandom_range(0, 3));
         w.source_ip   = $urandom;
         w.dest_ip     = $urandom;
         send_request(w);
      end
   endtask

   initial begin
      int unsigned phase_start;
      bit          paused;
      logic [7:0]  settings[6];

      book        = new();
      words_sent  = 0;
      req_gaps_on = 1'b1;
      rsp_gaps_on = 1'b1;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = '0;
      req_tlast   = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed datagrams at the reset protocol number.
      build_datagram(CMD_GENERATE, 8, 16'd8, STORE_RANDOM, FILL_ZEROS);
      send_datagram();
      build_datagram(ucc_pkg::CMD_VERIFY, 9, 16'd9, STORE_CORRECT, FILL_ONES);
      send_datagram();
      build_datagram(CMD_GENERATE, 13, 16'd13, STORE_RANDOM, FILL_ONES);
      send_datagram();
      build_datagram(ucc_pkg::CMD_VERIFY, 12, 16'd12, STORE_CORRECT, FILL_RANDOM);
      send_datagram();
      build_datagram(ucc_pkg::CMD_VERIFY, 12, 16'd12, STORE_ZERO, FILL_RANDOM);
      send_datagram();
      build_datagram(ucc_pkg::CMD_VERIFY, 12, 16'd12, STORE_RANDOM, FILL_RANDOM);
      send_datagram();
      // Runts, down to a single word that both opens and closes the datagram.
      build_datagram(CMD_GENERATE, 7, 16'd7, STORE_RANDOM, FILL_RANDOM);
      send_datagram();
      build_datagram(ucc_pkg::CMD_VERIFY, 2, 16'd8, STORE_RANDOM, FILL_RANDOM);
      send_datagram();
      build_datagram(CMD_GENERATE, 1, 16'd8, STORE_RANDOM, FILL_RANDOM);
      send_datagram();
      // Length field too short, zero, and longer than the data.
      build_datagram(ucc_pkg::CMD_VERIFY, 10, 16'd7, STORE_CORRECT, FILL_RANDOM);
      send_datagram();
      build_datagram(CMD_GENERATE, 10, 16'd0, STORE_RANDOM, FILL_RANDOM);
      send_datagram();
      build_datagram(ucc_pkg::CMD_VERIFY, 12, 16'd20, STORE_CORRECT, FILL_RANDOM);
      send_datagram();
      // Trailing bytes past the length field are left out of the sum.
      build_datagram(ucc_pkg::CMD_VERIFY, 21, 16'd12, STORE_CORRECT, FILL_RANDOM);
      send_datagram();
      // Words with no first word join a fresh frame after the previous result.
      build_datagram(ucc_pkg::CMD_VERIFY, 10, 16'd10, STORE_CORRECT, FILL_RANDOM);
      datagram_words[0].first = 1'b0;
      send_datagram();
      wait_for_results();

      // Random phases, each under its own protocol number.
      settings = '{8'd0, 8'd255, 8'd6, 8'($urandom), 8'($urandom), ucc_pkg::PROTOCOL_RESET};
      for (int p = 0; p < 6; p++) begin
         wait_for_results();
         repeat (4) @(posedge clock);
         write_protocol(settings[p]);
         req_gaps_on = (p != 2);
         rsp_gaps_on = (p != 2);
         phase_start = words_sent;
         paused = 1'b0;
         while (words_sent - phase_start < 190) begin
            if (!paused && words_sent - phase_start > 95) begin
               wait_for_results();
               paused = 1'b1;
            end
            if ($urandom_range(0, 99) < 12) send_noise();
            else random_datagram();
         end
         // Close the phase on a complete datagram before the next write.
         random_datagram();
      end

      wait_for_results();
      repeat (10) @(posedge clock);
      if (book.mismatches == 0 && book.pending() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

/* udp_checksum_check_generate.f */
hw/rtl/ucc_pkg.sv
hw/rtl/ucc_finish.sv
hw/rtl/udp_checksum_check_generate.sv
bench/tb_udp_checksum_check_generate.sv
